@@ rtl/tlbw_pkg.sv @@
// Shared types, constants and table functions for the TLB refill page walker.
package tlbw_pkg;

    localparam int VPN_W       = 20;
    localparam int FRAME_W     = 26;
    localparam int TBL_IDX_W   = 10;
    localparam logic [FRAME_W-1:0] FIRST_FRAME = 26'd4096;
    localparam logic [5:0]         LO_FLAGS    = 6'h16;

    typedef struct packed {
        logic [31:0] bad_address;
        logic [3:0]  process_id;
    } req_t;

    typedef struct packed {
        logic [31:0] entry_hi;
        logic [31:0] entry_lo_even;
        logic [31:0] entry_lo_odd;
        logic        found_in_table;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic has_table;
        logic ack;
    } scan_ctl_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_sts_t;

    // page table contents: entry j of every process holds VPN j
    function automatic logic [VPN_W-1:0] table_vpn(input logic [TBL_IDX_W-1:0] idx);
        return VPN_W'(idx);
    endfunction

    // frames run on across processes from the first frame
    function automatic logic [FRAME_W-1:0] table_frame(input logic [FRAME_W-1:0] base,
                                                     input logic [TBL_IDX_W-1:0] idx);
        return FIRST_FRAME + base + FRAME_W'(idx);
    endfunction

    function automatic logic [31:0] make_lo(input logic [FRAME_W-1:0] frame);
        return {frame, LO_FLAGS};
    endfunction

endpackage

@@ rtl/tlbw_scan.sv @@
// Page table scan engine: one shared VPN comparator stepped over the entries.
module tlbw_scan #(
    parameter int ENTRIES_PER_PROCESS = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  tlbw_pkg::scan_ctl_t                         ctl,
    input  logic [tlbw_pkg::VPN_W-1:0]                  vpn,
    output tlbw_pkg::scan_sts_t                         sts,
    output logic [$clog2(ENTRIES_PER_PROCESS)-1:0]      idx
);

    localparam int IDX_W = $clog2(ENTRIES_PER_PROCESS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES_PER_PROCESS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       hit_reg, hit_next;
    logic [tlbw_pkg::VPN_W-1:0] vpn_reg;
    logic                       hit_now;

    assign hit_now = tlbw_pkg::table_vpn(tlbw_pkg::TBL_IDX_W'(idx_reg)) == vpn_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ctl.has_table ? S_RUN : S_DONE;
                end
            end
            S_RUN:
            begin
                if (hit_now)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && ctl.start)
        begin
            vpn_reg <= vpn;
        end
    end

    assign sts.done = state_reg == S_DONE;
    assign sts.hit  = hit_reg;
    assign idx      = idx_reg;

endmodule

@@ rtl/tlbw_free_ctr.sv @@
// Free physical page counter, handing out an even/odd pair per allocation.
module tlbw_free_ctr #(
    parameter int NUM_PROCESSES       = 16,
    parameter int ENTRIES_PER_PROCESS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    output logic [tlbw_pkg::FRAME_W-1:0] frame_even,
    output logic [tlbw_pkg::FRAME_W-1:0] frame_odd
);

    localparam int FW = tlbw_pkg::FRAME_W;
    localparam logic [FW-1:0] RST_PAGE =
        tlbw_pkg::FIRST_FRAME + FW'(NUM_PROCESSES * ENTRIES_PER_PROCESS);

    logic [FW-1:0] page_reg, page_next;

    // wraps modulo 2^26
    assign page_next = advance ? page_reg + FW'(2) : page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= RST_PAGE;
        end
        else
        begin
            page_reg <= page_next;
        end
    end

    assign frame_even = page_reg;
    assign frame_odd  = page_reg + FW'(1);

endmodule

@@ rtl/tlb_refill_page_walker_core.sv @@
// TLB refill page walker top level: request capture, walk sequencing and result register.
//
// On each request transfer the core forms EntryHi from VPN/2 and the process id, then
// walks that process's page table one entry per clock through a single VPN comparator,
// stopping at the first entry that holds the faulting VPN. A full miss steps through every
// entry of the table; a process id with no table skips the walk, and its scan goes straight
// to done. Once the scan is done and the output slot is free, the result is loaded into
// the output register, from which it is offered as a result transfer.
// On a hit EntryLo0 carries the even page of the pair and EntryLo1 the odd one (frame
// zero when the last entry of an odd-sized table has no partner); on a miss two fresh
// frames come from a 26-bit wrapping free-page counter. The core takes one walk at a
// time: req_ready is high only between walks, while a finished result can still sit in
// the output register waiting for rsp_ready. Page table contents are fixed from reset,
// so no clearing pass is needed.
module tlb_refill_page_walker_core #(
    parameter int NUM_PROCESSES       = 16,
    parameter int ENTRIES_PER_PROCESS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tlbw_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tlbw_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(ENTRIES_PER_PROCESS);
    localparam int FW    = tlbw_pkg::FRAME_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES_PER_PROCESS - 1);
    localparam logic [FW-1:0]    ENTRIES_F = FW'(ENTRIES_PER_PROCESS);
    localparam logic [8:0]       NUM_PROC  = 9'(NUM_PROCESSES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                state_reg, state_next;
    tlbw_pkg::req_t      req_reg;
    logic [FW-1:0]       base_reg;
    tlbw_pkg::rsp_t      rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                accept;
    logic                out_free;
    logic                load;
    tlbw_pkg::scan_ctl_t scan_ctl;
    tlbw_pkg::scan_sts_t scan_sts;
    logic [IDX_W-1:0]    scan_idx;
    logic [IDX_W-1:0]    pair_idx;
    logic                no_partner;
    logic [FW-1:0]       tbl_even, tbl_odd;
    logic [FW-1:0]       free_even, free_odd;

    // ---- request side: one walk in flight at a time
    assign req_ready = state_reg == ST_IDLE;
    assign accept    = req_valid && req_ready;

    // ---- result side: load when the walk is done and the output slot frees up
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign load     = state_reg == ST_WALK && scan_sts.done && out_free;

    assign scan_ctl.start     = accept;
    assign scan_ctl.has_table = 9'(req.process_id) < NUM_PROC;
    assign scan_ctl.ack       = load;

    tlbw_scan #(
        .ENTRIES_PER_PROCESS (ENTRIES_PER_PROCESS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .vpn   (req.bad_address[31:12]),
        .sts   (scan_sts),
        .idx   (scan_idx)
    );

    tlbw_free_ctr #(
        .NUM_PROCESSES       (NUM_PROCESSES),
        .ENTRIES_PER_PROCESS (ENTRIES_PER_PROCESS)
    ) u_free_ctr (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (load && !scan_sts.hit),
        .frame_even (free_even),
        .frame_odd  (free_odd)
    );

    // ---- pair frames on a hit; even entry of the pair always goes to EntryLo0
    assign pair_idx   = scan_idx & ~IDX_W'(1);
    assign no_partner = !scan_idx[0] && scan_idx == LAST_IDX;
    assign tbl_even   = tlbw_pkg::table_frame(base_reg, tlbw_pkg::TBL_IDX_W'(pair_idx));
    assign tbl_odd    = no_partner ? '0 : tbl_even + FW'(1);

    always_comb
    begin
        rsp_next = rsp_reg;
        if (load)
        begin
            rsp_next.entry_hi       = {req_reg.bad_address[31:13], 9'b0, req_reg.process_id};
            rsp_next.found_in_table = scan_sts.hit;
            if (scan_sts.hit)
            begin
                rsp_next.entry_lo_even = tlbw_pkg::make_lo(tbl_even);
                rsp_next.entry_lo_odd  = tlbw_pkg::make_lo(tbl_odd);
            end
            else
            begin
                rsp_next.entry_lo_even = tlbw_pkg::make_lo(free_even);
                rsp_next.entry_lo_odd  = tlbw_pkg::make_lo(free_odd);
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req;
            base_reg <= FW'(req.process_id) * ENTRIES_F;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_WALK)
        else $error("walk did not start after request transfer");

    a_done_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        scan_sts.done |-> state_reg == ST_WALK)
        else $error("scan finished outside a walk");

    a_miss_takes_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !scan_sts.hit) |=> free_even == $past(free_even) + FW'(2))
        else $error("free page counter did not advance by a pair on a miss");

    a_hit_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.found_in_table) |->
            (rsp_reg.entry_lo_odd[31:6] == rsp_reg.entry_lo_even[31:6] + FW'(1)) ||
            (rsp_reg.entry_lo_odd == {26'b0, tlbw_pkg::LO_FLAGS}))
        else $error("hit returned a non-adjacent frame pair");

    a_hit_has_table: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.found_in_table) |->
            9'(rsp_reg.entry_hi[7:0]) < NUM_PROC)
        else $error("hit reported for a process without a table");
`endif

endmodule

@@ tb/tlb_refill_page_walker_core_test.sv @@
// Self-checking testbench for the TLB refill page walker core.
`timescale 1ns / 1ps

module tlb_refill_page_walker_core_test;

    localparam int NPROC        = 16;
    localparam int EPP          = 64;
    localparam int TABLE_DEPTH  = NPROC * EPP;
    localparam int RANDOM_WALKS = 400;
    localparam int CALM_WALKS   = 60;       // tail of the run with no idling on either side
    localparam int DRAIN_CYCLES = EPP + 8;  // a full miss walk plus some margin

    // One row of the directed table. Where typed is set, want is the result read
    // straight off the table layout; otherwise the predictor supplies it.
    typedef struct packed {
        tlbw_pkg::req_t walk;
        logic           typed;
        tlbw_pkg::rsp_t want;
    } probe_t;

    localparam int DIRECTED_ROWS = 15;
    localparam probe_t DIRECTED [DIRECTED_ROWS] = '{
        // VPN 0 of process 0 straight after reset: first frame pair of the table
        '{'{32'h0000_0000, 4'd0},  1'b1, '{32'h0000_0000, 32'h0004_0016, 32'h0004_0056, 1'b1}},
        // all ones: no table holds the VPN, so the first two free frames go out
        '{'{32'hFFFF_FFFF, 4'd15}, 1'b1, '{32'hFFFF_E00F, 32'h0005_0016, 32'h0005_0056, 1'b0}},
        // odd match on the last entry of the last table: partner at index 62 is the even page
        '{'{32'h0003_F000, 4'd15}, 1'b1, '{32'h0003_E00F, 32'h0004_FF96, 32'h0004_FFD6, 1'b1}},
        // odd match on entry 1 with page offset all ones
        '{'{32'h0000_1FFF, 4'd0},  1'b1, '{32'h0000_0000, 32'h0004_0016, 32'h0004_0056, 1'b1}},
        '{'{32'h0004_0000, 4'd3},  1'b0, '0},  // VPN 64, just past the table
        '{'{32'h0003_EABC, 4'd8},  1'b0, '0},  // even match at 62
        '{'{32'h8000_0000, 4'd0},  1'b0, '0},  // top bit only
        '{'{32'h7FFF_FFFF, 4'd1},  1'b0, '0},
        '{'{32'h0000_0FFF, 4'd7},  1'b0, '0},
        '{'{32'h0002_A555, 4'd10}, 1'b0, '0},
        '{'{32'h0001_5AAA, 4'd5},  1'b0, '0},  // odd match at 21
        '{'{32'hFFC0_0000, 4'd2},  1'b0, '0},  // low VPN bits zero but upper set: must miss
        '{'{32'h0010_0000, 4'd12}, 1'b0, '0},  // VPN 0x100 aliases entry 0 in six bits only
        '{'{32'h0000_0000, 4'd15}, 1'b0, '0},
        '{'{32'h0000_2000, 4'd9},  1'b0, '0}
    };

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    tlbw_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    tlbw_pkg::rsp_t rsp;

    tlb_refill_page_walker_core #(
        .NUM_PROCESSES       (NPROC),
        .ENTRIES_PER_PROCESS (EPP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Page table shadow and free-frame counter, mirroring the core's state
    // ------------------------------------------------------------------
    logic [tlbw_pkg::VPN_W-1:0]   pt_vpn   [TABLE_DEPTH];
    logic [tlbw_pkg::FRAME_W-1:0] pt_frame [TABLE_DEPTH];
    logic [tlbw_pkg::FRAME_W-1:0] free_frame;

    tlbw_pkg::rsp_t refill_due [$];   // results still owed by the core, oldest first
    int unsigned    faults       = 0;
    int unsigned    walks_sent   = 0;
    int unsigned    walks_hit    = 0;
    int unsigned    results_seen = 0;
    bit             calm         = 1'b0;  // set for the final stretch: no idling anywhere
    int unsigned    gap_pct      = 0;     // chance of a request gap, redrawn per block of walks

    function automatic void load_page_tables();
        logic [tlbw_pkg::FRAME_W-1:0] frame;
        frame = tlbw_pkg::FIRST_FRAME;
        for (int p = 0; p < NPROC; p++)
            for (int j = 0; j < EPP; j++)
            begin
                pt_vpn[p*EPP + j]   = tlbw_pkg::VPN_W'(j);
                pt_frame[p*EPP + j] = frame;
                frame               = frame + tlbw_pkg::FRAME_W'(1);
            end
        free_frame = frame;
    endfunction

    function automatic logic [31:0] lo_word(input logic [tlbw_pkg::FRAME_W-1:0] frame);
        return (32'(frame) << 6) | 32'(tlbw_pkg::LO_FLAGS);
    endfunction

    // Works out the refill for one walk; a miss consumes two frames from the counter.
    function automatic tlbw_pkg::rsp_t predict_refill(input tlbw_pkg::req_t walk);
        logic [tlbw_pkg::VPN_W-1:0] vpn;
        int                         base;
        tlbw_pkg::rsp_t             r;
        vpn              = walk.bad_address[31:12];
        r.entry_hi       = {vpn[tlbw_pkg::VPN_W-1:1], 13'd0} | 32'(walk.process_id);
        r.entry_lo_even  = '0;
        r.entry_lo_odd   = '0;
        r.found_in_table = 1'b0;
        if (int'(walk.process_id) < NPROC)
        begin
            base = int'(walk.process_id) * EPP;
            for (int i = 0; i < EPP; i++)
                if (!r.found_in_table && pt_vpn[base + i] == vpn)
                begin
                    r.found_in_table = 1'b1;
                    if (i % 2 == 0)
                    begin
                        r.entry_lo_even = lo_word(pt_frame[base + i]);
                        // an odd-sized table leaves the last even entry without a partner
                        r.entry_lo_odd  = (i + 1 < EPP) ? lo_word(pt_frame[base + i + 1])
                                                        : lo_word('0);
                    end
                    else
                    begin
                        r.entry_lo_even = lo_word(pt_frame[base + i - 1]);
                        r.entry_lo_odd  = lo_word(pt_frame[base + i]);
                    end
                end
        end
        if (!r.found_in_table)
        begin
            r.entry_lo_even = lo_word(free_frame);
            free_frame      = free_frame + tlbw_pkg::FRAME_W'(1);
            r.entry_lo_odd  = lo_word(free_frame);
            free_frame      = free_frame + tlbw_pkg::FRAME_W'(1);
        end
        return r;
    endfunction

    // Mostly table hits with random offsets and processes, then near misses just
    // above the table, then fully random addresses that almost always miss.
    function automatic tlbw_pkg::req_t draw_walk();
        tlbw_pkg::req_t w;
        int unsigned    pick;
        pick           = $urandom_range(0, 99);
        w.bad_address  = $urandom;
        w.process_id   = 4'($urandom_range(0, NPROC - 1));
        if (pick < 60)
            w.bad_address = {14'd0, 6'($urandom), 12'($urandom)};
        else if (pick < 75)
            w.bad_address = {13'd0, 1'b1, 6'($urandom), 12'($urandom)};
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Holds the request until the transfer, then queues what it should produce.
    task automatic issue(input tlbw_pkg::req_t walk, input logic typed,
                         input tlbw_pkg::rsp_t want);
        tlbw_pkg::rsp_t model;
        req_valid <= 1'b1;
        req       <= walk;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        model = predict_refill(walk);
        refill_due.push_back(typed ? want : model);
        walks_sent++;
        if (model.found_in_table)
            walks_hit++;
    endtask

    // Gap of random length with valid low; called only straight after a transfer
    // or before the first one, so valid is never dropped and raised in one step.
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    initial
    begin
        load_page_tables();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 40;
        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            maybe_gap();
            issue(DIRECTED[k].walk, DIRECTED[k].typed, DIRECTED[k].want);
        end

        for (int n = 0; n < RANDOM_WALKS; n++)
        begin
            // gap density changes in blocks so that busy stretches occur too
            if (n % 32 == 0)
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 30;
                    default: gap_pct = 70;
                endcase
            calm = (n >= RANDOM_WALKS - CALM_WALKS);
            maybe_gap();
            issue(draw_walk(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (refill_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d walk transfers issued, %0d results checked", walks_sent, results_seen);
        $display("%0d table hits, %0d fresh frame pairs handed out",
                 walks_hit, walks_sent - walks_hit);
        if (faults == 0 && refill_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready toggles in bursts, settles high for the calm tail
    // ------------------------------------------------------------------
    initial
    begin : ready_driver
        int unsigned stall_pct;
        stall_pct = 30;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                stall_pct = $urandom_range(0, 2) * 35;
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 11))
                    @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20))
                @(posedge clk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            faults++;
        end
    endtask

    // Values read here are those sampled at the edge, before this step's updates.
    always @(posedge clk)
    begin : result_monitor
        tlbw_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (refill_due.size() == 0)
            begin
                $error("result transfer with nothing outstanding: %h", rsp);
                faults++;
            end
            else
            begin
                want = refill_due.pop_front();
                check_field("entry_hi",       want.entry_hi,       rsp.entry_hi);
                check_field("entry_lo_even",  want.entry_lo_even,  rsp.entry_lo_even);
                check_field("entry_lo_odd",   want.entry_lo_odd,   rsp.entry_lo_odd);
                check_field("found_in_table", 32'(want.found_in_table),
                            32'(rsp.found_in_table));
            end
        end
    end

    // Watchdog: slowest legal run is well under 0.4 ms.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", refill_due.size());
        $display("status: fail");
        $finish;
    end

endmodule

@@ tlb_refill_page_walker_core.f @@
rtl/tlbw_pkg.sv
rtl/tlbw_scan.sv
rtl/tlbw_free_ctr.sv
rtl/tlb_refill_page_walker_core.sv
tb/tlb_refill_page_walker_core_test.sv
